[rtl/particle_table_integrate_expire_macros.svh]
// assertion macros for the particle table block
// depends on clk and rst_n being visible where a macro is used
`ifndef PARTICLE_TABLE_INTEGRATE_EXPIRE_MACROS_SVH
`define PARTICLE_TABLE_INTEGRATE_EXPIRE_MACROS_SVH
`ifndef SYNTHESIS
`define PTIE_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define PTIE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define PTIE_ASSERT(label, cond)
`define PTIE_ASSERT_NEXT(label, pre, post)
`endif
`endif

[rtl/ptie_pkg.sv]
// shared types, codes and arithmetic helpers for the particle table block
// no dependencies
package ptie_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SIZE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE     = 3'd4;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_T_RD,
        ST_T_MX,
        ST_T_AX,
        ST_T_AY,
        ST_T_AR,
        ST_C_RD,
        ST_C_CHK,
        ST_C_MV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [23:0] in_pos_x;
        logic signed [23:0] in_pos_y;
        logic signed [15:0] in_vel_x;
        logic signed [15:0] in_vel_y;
        logic [15:0]        in_lifetime;
        logic signed [23:0] in_rotation;
        logic signed [15:0] in_spin;
        logic [15:0]        time_step;
        logic [7:0]         read_index;
    } in_t;

    typedef struct packed {
        logic               ok;
        logic [8:0]         live_count;
        logic signed [23:0] out_pos_x;
        logic signed [23:0] out_pos_y;
        logic [15:0]        out_age;
        logic [15:0]        out_lifetime;
        logic signed [23:0] out_rotation;
        logic [15:0]        out_start_size;
        logic [15:0]        out_end_size;
        logic [31:0]        out_start_color;
        logic [31:0]        out_end_color;
        logic [7:0]         out_texture;
    } res_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [15:0]        age;
        logic [15:0]        life;
        logic signed [23:0] rot;
        logic signed [15:0] spin;
        logic [15:0]        start_size;
        logic [15:0]        end_size;
        logic [31:0]        start_color;
        logic [31:0]        end_color;
        logic [7:0]         tex;
    } entry_t;

    typedef struct packed {
        req_t        kind;
        entry_t      entry;
        logic [15:0] dt;
        logic [7:0]  rindex;
    } cmd_t;

    // p + round(prod / 2^16), saturated to 24 bits
    function automatic logic signed [23:0] advance(input logic signed [23:0] p,
                                                   input logic signed [32:0] prod);
        logic signed [33:0] biased;
        logic signed [17:0] delta;
        logic signed [25:0] s;
        biased = $signed({prod[32], prod}) + 34'sd32768;
        delta  = biased[33:16];
        s      = $signed({{2{p[23]}}, p}) + $signed({{8{delta[17]}}, delta});
        if (s > 26'sd8388607)
            return 24'sh7FFFFF;
        else if (s < -26'sd8388608)
            return 24'sh800000;
        else
            return s[23:0];
    endfunction

    function automatic logic [15:0] age_step(input logic [15:0] age, input logic [15:0] dt);
        logic [16:0] dage;
        logic [16:0] a;
        dage = (17'(dt) + 17'd128) >> 8;
        a    = 17'(age) + dage;
        return a[16] ? 16'hFFFF : a[15:0];
    endfunction

endpackage

[rtl/ptie_fifo.sv]
// small register queue used between front and back and on the result side
// depends on nothing
module ptie_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= wdata;
    end
endmodule

[rtl/ptie_front.sv]
// front part: spawn registers and request classification into commands
// depends on ptie_pkg
module ptie_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptie_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptie_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  ptie_pkg::in_t                       request,
    output ptie_pkg::cmd_t                      cmd
);
    logic [15:0] start_size_reg;
    logic [15:0] end_size_reg;
    logic [31:0] start_color_reg;
    logic [31:0] end_color_reg;
    logic [7:0]  texture_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_size_reg  <= 16'd256;
            end_size_reg    <= 16'd0;
            start_color_reg <= 32'hFFFFFFFF;
            end_color_reg   <= 32'd0;
            texture_reg     <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptie_pkg::CFG_START_SIZE:  start_size_reg  <= cfg_data[15:0];
                ptie_pkg::CFG_END_SIZE:    end_size_reg    <= cfg_data[15:0];
                ptie_pkg::CFG_START_COLOR: start_color_reg <= cfg_data;
                ptie_pkg::CFG_END_COLOR:   end_color_reg   <= cfg_data;
                ptie_pkg::CFG_TEXTURE:     texture_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cmd.kind              = ptie_pkg::req_t'(request.req_type);
        cmd.entry.x           = request.in_pos_x;
        cmd.entry.y           = request.in_pos_y;
        cmd.entry.vx          = request.in_vel_x;
        cmd.entry.vy          = request.in_vel_y;
        cmd.entry.age         = 16'd0;
        cmd.entry.life        = request.in_lifetime;
        cmd.entry.rot         = request.in_rotation;
        cmd.entry.spin        = request.in_spin;
        cmd.entry.start_size  = start_size_reg;
        cmd.entry.end_size    = end_size_reg;
        cmd.entry.start_color = start_color_reg;
        cmd.entry.end_color   = end_color_reg;
        cmd.entry.tex         = texture_reg;
        cmd.dt                = request.time_step;
        cmd.rindex            = request.read_index;
    end
endmodule

[rtl/ptie_back.sv]
// back part: particle table memory and the command sequencer
// depends on ptie_pkg
module ptie_back #(
    parameter int CAPACITY = ptie_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ptie_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output ptie_pkg::res_t res
);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    ptie_pkg::entry_t mem [CAPACITY];
    ptie_pkg::entry_t rd_data;

    ptie_pkg::back_state_t state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    ptie_pkg::entry_t      work_reg, work_next;
    logic signed [32:0]    prod_reg, prod_next;
    ptie_pkg::cmd_t        cmd_reg, cmd_next;
    logic                  ok_reg, ok_next;
    logic                  hit_reg, hit_next;

    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_raddr;
    ptie_pkg::entry_t      mem_wdata;
    ptie_pkg::entry_t      upd;
    logic signed [15:0]    mul_a;
    logic signed [32:0]    mul_p;
    logic                  take, room, rhit, expired, idx_last;

    assign take     = !cmd_empty && !res_full;
    assign room     = 32'(count_reg) < CAPACITY;
    assign rhit     = 32'(cmd_reg.rindex) < 32'(count_reg);
    assign expired  = rd_data.age >= rd_data.life;
    assign idx_last = (32'(idx_reg) + 1) >= 32'(count_reg);
    assign mul_p    = mul_a * $signed({1'b0, cmd_reg.dt});

    always_comb
    begin
        upd     = work_reg;
        upd.rot = ptie_pkg::advance(work_reg.rot, prod_reg);
        upd.age = ptie_pkg::age_step(work_reg.age, cmd_reg.dt);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptie_pkg::ST_IDLE:  if (take) state_next = ptie_pkg::ST_EXEC;
            ptie_pkg::ST_EXEC:
            begin
                if (cmd_reg.kind == ptie_pkg::REQ_TICK && count_reg != '0)
                    state_next = ptie_pkg::ST_T_RD;
                else
                    state_next = ptie_pkg::ST_DONE;
            end
            ptie_pkg::ST_T_RD:  state_next = ptie_pkg::ST_T_MX;
            ptie_pkg::ST_T_MX:  state_next = ptie_pkg::ST_T_AX;
            ptie_pkg::ST_T_AX:  state_next = ptie_pkg::ST_T_AY;
            ptie_pkg::ST_T_AY:  state_next = ptie_pkg::ST_T_AR;
            ptie_pkg::ST_T_AR:  state_next = idx_last ? ptie_pkg::ST_C_RD : ptie_pkg::ST_T_RD;
            ptie_pkg::ST_C_RD:  state_next = ptie_pkg::ST_C_CHK;
            ptie_pkg::ST_C_CHK:
            begin
                if (idx_last)
                    state_next = ptie_pkg::ST_DONE;
                else if (expired)
                    state_next = ptie_pkg::ST_C_MV;
                else
                    state_next = ptie_pkg::ST_C_RD;
            end
            ptie_pkg::ST_C_MV:  state_next = ptie_pkg::ST_C_CHK;
            ptie_pkg::ST_DONE:  state_next = ptie_pkg::ST_IDLE;
            default:            state_next = ptie_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = idx_reg;
        mem_raddr  = idx_reg;
        mem_wdata  = work_reg;
        mul_a      = '0;
        count_next = count_reg;
        idx_next   = idx_reg;
        work_next  = work_reg;
        prod_next  = prod_reg;
        cmd_next   = cmd_reg;
        ok_next    = ok_reg;
        hit_next   = hit_reg;
        case (state_reg)
            ptie_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                end
            end
            ptie_pkg::ST_EXEC:
            begin
                hit_next = 1'b0;
                ok_next  = 1'b1;
                case (cmd_reg.kind)
                    ptie_pkg::REQ_INSERT:
                    begin
                        if (room)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = IDX_W'(count_reg);
                            mem_wdata  = cmd_reg.entry;
                            count_next = count_reg + 1'b1;
                        end
                        else
                            ok_next = 1'b0;
                    end
                    ptie_pkg::REQ_TICK:  idx_next = '0;
                    ptie_pkg::REQ_READ:
                    begin
                        hit_next  = rhit;
                        ok_next   = rhit;
                        mem_re    = rhit;
                        mem_raddr = IDX_W'(cmd_reg.rindex);
                    end
                    ptie_pkg::REQ_CLEAR: count_next = '0;
                    default: ;
                endcase
            end
            ptie_pkg::ST_T_RD:  mem_re = 1'b1;
            ptie_pkg::ST_T_MX:
            begin
                work_next = rd_data;
                mul_a     = rd_data.vx;
                prod_next = mul_p;
            end
            ptie_pkg::ST_T_AX:
            begin
                work_next.x = ptie_pkg::advance(work_reg.x, prod_reg);
                mul_a       = work_reg.vy;
                prod_next   = mul_p;
            end
            ptie_pkg::ST_T_AY:
            begin
                work_next.y = ptie_pkg::advance(work_reg.y, prod_reg);
                mul_a       = work_reg.spin;
                prod_next   = mul_p;
            end
            ptie_pkg::ST_T_AR:
            begin
                work_next = upd;
                mem_we    = 1'b1;
                mem_wdata = upd;
                idx_next  = idx_last ? '0 : idx_reg + 1'b1;
            end
            ptie_pkg::ST_C_RD:  mem_re = 1'b1;
            ptie_pkg::ST_C_CHK:
            begin
                if (expired && idx_last)
                    count_next = count_reg - 1'b1;
                else if (expired)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = IDX_W'(count_reg - 1'b1);
                end
                else if (!idx_last)
                    idx_next = idx_reg + 1'b1;
            end
            ptie_pkg::ST_C_MV:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data;
                count_next = count_reg - 1'b1;
            end
            ptie_pkg::ST_DONE:  res_push = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        res.ok              = ok_reg;
        res.live_count      = 9'(count_reg);
        res.out_pos_x       = hit_reg ? rd_data.x : '0;
        res.out_pos_y       = hit_reg ? rd_data.y : '0;
        res.out_age         = hit_reg ? rd_data.age : '0;
        res.out_lifetime    = hit_reg ? rd_data.life : '0;
        res.out_rotation    = hit_reg ? rd_data.rot : '0;
        res.out_start_size  = hit_reg ? rd_data.start_size : '0;
        res.out_end_size    = hit_reg ? rd_data.end_size : '0;
        res.out_start_color = hit_reg ? rd_data.start_color : '0;
        res.out_end_color   = hit_reg ? rd_data.end_color : '0;
        res.out_texture     = hit_reg ? rd_data.tex : '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptie_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        work_reg <= work_next;
        prod_reg <= prod_next;
        cmd_reg  <= cmd_next;
        ok_reg   <= ok_next;
        hit_reg  <= hit_next;
    end
endmodule

[rtl/particle_table_integrate_expire.sv]
// top level of the particle table: front, command queue, back and result queue
// depends on ptie_pkg, ptie_fifo, ptie_front, ptie_back and the macro header
//
// requests enter through push/full; an item is taken when push is high and full low.
// results leave through empty/pop, one per request, oldest first, in request order.
// spawn registers are written through cfg_we/cfg_index/cfg_data, by the user only while
// the block is idle, unenforced by the block itself. a two-entry command queue sits
// between the front and the table sequencer, and a two-entry result queue holds finished
// results, so a stalled receiver only stops the sequencer once that queue is full;
// requests keep queuing until full rises. insert, read and clear go through the states
// IDLE, EXEC and DONE. a tick adds a motion pass, T_RD, T_MX, T_AX, T_AY and T_AR per
// live entry (one table port, one shared multiplier, three products per entry), then a
// compaction pass of C_RD and C_CHK per entry checked plus C_MV per removal. one item is
// worked at a time: the sequencer takes the next command only after pushing a result.
// reset empties the table and the queues and loads the spawn register defaults;
// the table memory itself is not cleared, only the live count.
`include "particle_table_integrate_expire_macros.svh"
module particle_table_integrate_expire #(
    parameter int CAPACITY = ptie_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  ptie_pkg::in_t                   request,
    output logic                            empty,
    input  logic                            pop,
    output ptie_pkg::res_t                  result,
    input  logic                            cfg_we,
    input  logic [ptie_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptie_pkg::CFG_DATA_W-1:0] cfg_data
);
    ptie_pkg::cmd_t cmd_in, cmd_out;
    ptie_pkg::res_t res_in;
    logic cmd_empty, cmd_pop, res_full, res_push;

    ptie_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (cmd_in)
    );

    ptie_fifo #(
        .WIDTH ($bits(ptie_pkg::cmd_t)),
        .DEPTH (ptie_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    ptie_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    ptie_fifo #(
        .WIDTH ($bits(ptie_pkg::res_t)),
        .DEPTH (ptie_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    `PTIE_ASSERT(a_cmd_pop_valid, !cmd_pop || !cmd_empty)
    `PTIE_ASSERT(a_res_push_room, !res_push || !res_full)
    `PTIE_ASSERT_NEXT(a_cmd_queued, push && !full, !cmd_empty)
    `PTIE_ASSERT_NEXT(a_one_result_per_pop, res_push, !res_push)
endmodule

[dv/tb.sv]
// testbench for particle_table_integrate_expire: directed and random requests,
// checked against a behavioral model of the particle table kept in this file
// depends on ptie_pkg and the particle_table_integrate_expire rtl
module tb;
    import ptie_pkg::*;

    localparam int CAP = 256;
    localparam int WATCHDOG_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_t request;
    logic empty;
    logic pop;
    res_t result;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    particle_table_integrate_expire uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .request(request),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // model state
    entry_t table_m [CAP];
    int unsigned live_m;
    logic [15:0] sp_start_size;
    logic [15:0] sp_end_size;
    logic [31:0] sp_start_color;
    logic [31:0] sp_end_color;
    logic [7:0] sp_texture;

    res_t expected_results[$];
    int errors;
    int items_sent;
    int results_seen;
    int reads_ok;
    int expiries;
    int idle_cycles;
    bit tx_idle_en;
    bit rx_idle_en;
    int hold_rx;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [23:0] step_axis(logic signed [23:0] p,
                                                     logic signed [15:0] v,
                                                     logic [15:0] dt);
        longint prod;
        longint delta;
        longint s;
        prod = longint'(v) * longint'(dt) + 32768;
        delta = prod >>> 16;
        s = longint'(p) + delta;
        if (s > 8388607)
            s = 8388607;
        if (s < -8388608)
            s = -8388608;
        return s[23:0];
    endfunction

    function automatic res_t table_predict(in_t r);
        res_t o;
        int unsigned i;
        int unsigned a;
        int unsigned dage;
        o = '0;
        o.ok = 1'b1;
        case (req_t'(r.req_type))
            REQ_INSERT:
            begin
                if (live_m >= CAP)
                    o.ok = 1'b0;
                else
                begin
                    table_m[live_m] = '{x: r.in_pos_x, y: r.in_pos_y, vx: r.in_vel_x,
                        vy: r.in_vel_y, age: 16'd0, life: r.in_lifetime,
                        rot: r.in_rotation, spin: r.in_spin,
                        start_size: sp_start_size, end_size: sp_end_size,
                        start_color: sp_start_color, end_color: sp_end_color,
                        tex: sp_texture};
                    live_m++;
                end
            end
            REQ_TICK:
            begin
                dage = (int'(r.time_step) + 128) >> 8;
                for (i = 0; i < live_m; i++)
                begin
                    table_m[i].x = step_axis(table_m[i].x, table_m[i].vx, r.time_step);
                    table_m[i].y = step_axis(table_m[i].y, table_m[i].vy, r.time_step);
                    table_m[i].rot = step_axis(table_m[i].rot, table_m[i].spin,
                                               r.time_step);
                    a = table_m[i].age + dage;
                    table_m[i].age = (a > 65535) ? 16'hFFFF : a[15:0];
                end
                i = 0;
                while (i < live_m)
                begin
                    if (table_m[i].age >= table_m[i].life)
                    begin
                        table_m[i] = table_m[live_m - 1];
                        live_m--;
                        expiries++;
                    end
                    else
                        i++;
                end
            end
            REQ_READ:
            begin
                if (r.read_index < live_m)
                begin
                    o.out_pos_x = table_m[r.read_index].x;
                    o.out_pos_y = table_m[r.read_index].y;
                    o.out_age = table_m[r.read_index].age;
                    o.out_lifetime = table_m[r.read_index].life;
                    o.out_rotation = table_m[r.read_index].rot;
                    o.out_start_size = table_m[r.read_index].start_size;
                    o.out_end_size = table_m[r.read_index].end_size;
                    o.out_start_color = table_m[r.read_index].start_color;
                    o.out_end_color = table_m[r.read_index].end_color;
                    o.out_texture = table_m[r.read_index].tex;
                    reads_ok++;
                end
                else
                    o.ok = 1'b0;
            end
            default:
                live_m = 0;
        endcase
        o.live_count = live_m[8:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    task automatic random_gap(bit en);
        int n;
        if (en && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_item(in_t r);
        random_gap(tx_idle_en);
        push <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_results = {expected_results, table_predict(r)};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_SIZE: sp_start_size = val[15:0];
            CFG_END_SIZE: sp_end_size = val[15:0];
            CFG_START_COLOR: sp_start_color = val;
            CFG_END_COLOR: sp_end_color = val;
            CFG_TEXTURE: sp_texture = val[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function automatic in_t rand_item();
        in_t r;
        r = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return r;
    endfunction

    function automatic in_t mk_insert(logic [15:0] life);
        in_t r;
        r = rand_item();
        r.req_type = REQ_INSERT;
        r.in_lifetime = life;
        return r;
    endfunction

    function automatic in_t mk_tick(logic [15:0] dt);
        in_t r;
        r = rand_item();
        r.req_type = REQ_TICK;
        r.time_step = dt;
        return r;
    endfunction

    function automatic in_t mk_read(logic [7:0] idx);
        in_t r;
        r = rand_item();
        r.req_type = REQ_READ;
        r.read_index = idx;
        return r;
    endfunction

    task automatic write_all_regs(bit extreme_hi);
        write_reg(CFG_START_SIZE, extreme_hi ? 32'hFFFF : $urandom_range(0, 65535));
        write_reg(CFG_END_SIZE, extreme_hi ? 32'h0 : $urandom_range(0, 65535));
        write_reg(CFG_START_COLOR, extreme_hi ? 32'h0 : $urandom);
        write_reg(CFG_END_COLOR, extreme_hi ? 32'hFFFFFFFF : $urandom);
        write_reg(CFG_TEXTURE, extreme_hi ? 32'hFF : $urandom_range(0, 255));
    endtask

    task automatic test_directed();
        in_t r;
        send_item(mk_read(8'd0));
        send_item(mk_tick(16'd0));
        r = mk_insert(16'hFFFF);
        r.in_pos_x = 24'sh7FFFFF;
        r.in_pos_y = 24'sh800000;
        r.in_vel_x = 16'sh7FFF;
        r.in_vel_y = 16'sh8000;
        r.in_rotation = 24'sh7FFFFF;
        r.in_spin = 16'sh7FFF;
        send_item(r);
        r = mk_insert(16'h0000);
        r.in_pos_x = 24'sh800000;
        r.in_pos_y = 24'sh7FFFFF;
        r.in_vel_x = 16'sh8000;
        r.in_vel_y = 16'sh7FFF;
        r.in_rotation = 24'sh800000;
        r.in_spin = 16'sh8000;
        send_item(r);
        send_item(mk_insert(16'h0100));
        send_item(mk_read(8'd1));
        send_item(mk_tick(16'd0));
        send_item(mk_read(8'd0));
        send_item(mk_read(8'd1));
        send_item(mk_tick(16'hFFFF));
        send_item(mk_read(8'd0));
        send_item(mk_read(8'd255));
        send_item(mk_tick(16'h0080));
        send_item(mk_tick(16'h007F));
        r = rand_item();
        r.req_type = REQ_CLEAR;
        send_item(r);
        send_item(mk_read(8'd0));
        wait_drained();
    endtask

    task automatic test_full_table();
        int k;
        write_all_regs(1'b1);
        for (k = 0; k < CAP + 2; k++)
            send_item(mk_insert(16'hFFFF));
        send_item(mk_read(8'd255));
        send_item(mk_read(8'd0));
        send_item(mk_tick(16'h1234));
        send_item(mk_read(8'd128));
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        hold_rx = 200;
        for (k = 0; k < 12; k++)
            send_item(mk_read(8'($urandom_range(0, 255))));
        wait_drained();
    endtask

    task automatic test_random(int n, bit idle);
        int k;
        int sel;
        in_t r;
        tx_idle_en = idle;
        rx_idle_en = idle;
        for (k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                r = mk_insert(16'($urandom_range(0, 1200)));
                if ($urandom_range(0, 9) == 0)
                    r.in_lifetime = 16'($urandom);
            end
            else if (sel < 60)
            begin
                r = mk_tick(16'($urandom_range(0, 20000)));
                if ($urandom_range(0, 5) == 0)
                    r.time_step = 16'($urandom);
            end
            else if (sel < 97)
                r = mk_read(8'($urandom_range(0, live_m + 2)));
            else
            begin
                r = rand_item();
                r.req_type = REQ_CLEAR;
            end
            if (sel >= 97 || $urandom_range(0, 49) == 0)
                r.read_index = 8'($urandom);
            send_item(r);
        end
        wait_drained();
    endtask

    // result checker and receiver idling
    initial
    begin
        res_t want;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rx > 0)
            begin
                pop <= 1'b0;
                hold_rx--;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end
            else
                pop <= 1'b1;
            @(posedge clk);
            if (pop && !empty && rst_n)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result %0d", results_seen);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.ok !== want.ok)
                        report_mismatch("ok", result.ok, want.ok);
                    if (result.live_count !== want.live_count)
                        report_mismatch("live_count", result.live_count, want.live_count);
                    if (result.out_pos_x !== want.out_pos_x)
                        report_mismatch("out_pos_x", result.out_pos_x, want.out_pos_x);
                    if (result.out_pos_y !== want.out_pos_y)
                        report_mismatch("out_pos_y", result.out_pos_y, want.out_pos_y);
                    if (result.out_age !== want.out_age)
                        report_mismatch("out_age", result.out_age, want.out_age);
                    if (result.out_lifetime !== want.out_lifetime)
                        report_mismatch("out_lifetime", result.out_lifetime,
                                        want.out_lifetime);
                    if (result.out_rotation !== want.out_rotation)
                        report_mismatch("out_rotation", result.out_rotation,
                                        want.out_rotation);
                    if (result.out_start_size !== want.out_start_size)
                        report_mismatch("out_start_size", result.out_start_size,
                                        want.out_start_size);
                    if (result.out_end_size !== want.out_end_size)
                        report_mismatch("out_end_size", result.out_end_size,
                                        want.out_end_size);
                    if (result.out_start_color !== want.out_start_color)
                        report_mismatch("out_start_color", result.out_start_color,
                                        want.out_start_color);
                    if (result.out_end_color !== want.out_end_color)
                        report_mismatch("out_end_color", result.out_end_color,
                                        want.out_end_color);
                    if (result.out_texture !== want.out_texture)
                        report_mismatch("out_texture", result.out_texture,
                                        want.out_texture);
                end
            end
        end
    end

    // watchdog on cycles with no item moving either way
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("particle_table_integrate_expire test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        reads_ok = 0;
        expiries = 0;
        hold_rx = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        live_m = 0;
        sp_start_size = 16'd256;
        sp_end_size = 16'd0;
        sp_start_color = 32'hFFFFFFFF;
        sp_end_color = 32'd0;
        sp_texture = 8'd0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_full_table();
        test_backpressure();
        write_all_regs(1'b0);
        test_random(150, 1'b1);
        write_reg(CFG_START_SIZE, 32'h0);
        write_reg(CFG_END_SIZE, 32'hFFFF);
        write_reg(CFG_START_COLOR, 32'hFFFFFFFF);
        write_reg(CFG_END_COLOR, 32'h0);
        write_reg(CFG_TEXTURE, 32'h0);
        test_random(150, 1'b1);
        write_all_regs(1'b0);
        test_random(150, 1'b0);
        $display("sent %0d items, checked %0d results, %0d entry reads, %0d expiries",
                 items_sent, results_seen, reads_ok, expiries);
        if (errors == 0)
            $display("particle_table_integrate_expire test passed");
        else
            $display("particle_table_integrate_expire test failed");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/ptie_pkg.sv
rtl/ptie_fifo.sv
rtl/ptie_front.sv
rtl/ptie_back.sv
rtl/particle_table_integrate_expire.sv
dv/tb.sv
